// ===== src/krst_pkg.sv =====
package krst_pkg;

   localparam int CAPACITY    = 256;
   localparam int HANDLE_BITS = 16;
   localparam int IDX_BITS    = 8;
   localparam int LINK_BITS   = 9;
   localparam int STEP_BITS   = 9;

   localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(CAPACITY);

   typedef enum logic [2:0] {
      RES_WAITER_STORED = 3'd0,
      RES_TERM_STORED   = 3'd1,
      RES_WAITER_NOTIFY = 3'd2,
      RES_ALREADY_TERM  = 3'd3,
      RES_FULL          = 3'd4,
      RES_ANOMALY       = 3'd5,
      RES_INVALID_KEY   = 3'd6
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DESC, S_FREE, S_LINK, S_LCHK, S_LRD, S_REM1, S_REM2, S_REM3
   } state_type;

   typedef struct packed {
      logic [30:0]            key;
      logic                   has_handle;
      logic [HANDLE_BITS-1:0] handle;
      logic [31:0]            status;
      logic [LINK_BITS-1:0]   left;
      logic [LINK_BITS-1:0]   right;
   } node_type;

   function automatic logic link_ok(input logic [LINK_BITS-1:0] l);
      return l < NULL_LINK;
   endfunction

endpackage

// ===== src/key_rendezvous_search_tree.sv =====
// Rendezvous table of process keys kept in a digital search tree.
// Request channel: drive req_func, req_key, req_handle, req_exit_status and
// pulse start while busy is low; the word is taken at that edge. func 0 is a
// termination report (exit status), func 1 a waiter registration (handle).
// Response channel: one word per request, shown for exactly one cycle with
// rsp_valid high; the receiver cannot stall, so capture it in that cycle.
// rsp_notify flags a removal, with the handle and status to hand the waiter.
// A negative key answers in the cycle right after the accept edge. Otherwise
// the walk reads nodes one at a time through the single node memory read port:
// the key descent, then on a match the leaf search and the removal writes.
// busy stays high for the whole walk and no new request is taken meanwhile.
// Reset: all nodes read as cleared and chained on the free list in index
// order, the tree is empty. Per-entry valid bits give this at once, so there
// is no clearing pass after reset.
module key_rendezvous_search_tree (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic signed [31:0] req_key,
   input  logic [krst_pkg::HANDLE_BITS-1:0] req_handle,
   input  logic signed [31:0] req_exit_status,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_code,
   output logic        rsp_notify,
   output logic [krst_pkg::HANDLE_BITS-1:0] rsp_notify_handle,
   output logic signed [31:0] rsp_notify_status
);
   import krst_pkg::*;

   // node memory, one read and one write port, registered read
   node_type mem [CAPACITY];
   logic [CAPACITY-1:0] vld_ff;

   node_type rd_w_ff;
   logic [IDX_BITS-1:0] rd_idx_ff;
   logic rd_v_ff;
   node_type eff_w;

   logic [IDX_BITS-1:0] ra;
   logic we;
   logic [IDX_BITS-1:0] wa;
   node_type wd;

   state_type st_ff, st_in;
   logic func_ff;
   logic [31:0] key_ff;
   logic [HANDLE_BITS-1:0] hnd_ff;
   logic [31:0] sta_ff;

   logic [LINK_BITS-1:0] root_ff, root_in, free_ff, free_in;
   logic [LINK_BITS-1:0] rover_ff, rover_in, last_ff, last_in;
   logic [LINK_BITS-1:0] leaf_ff, leaf_in, prev_ff, prev_in;
   node_type last_w_ff, last_w_in, rover_w_ff, rover_w_in;
   node_type leaf_w_ff, leaf_w_in, prev_w_ff, prev_w_in;
   logic last_ok_ff, last_ok_in, lastbit_ff, lastbit_in, rootins_ff, rootins_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [HANDLE_BITS-1:0] nh_ff, nh_in;
   logic [31:0] ns_ff, ns_in;

   logic rv_ff, rv_in, rn_ff, rn_in;
   result_type rc_ff, rc_in;
   logic [HANDLE_BITS-1:0] rh_ff, rh_in;
   logic [31:0] rs_ff, rs_in;

   logic accept;
   assign accept = start && !busy;
   assign busy = (st_ff != S_IDLE);

   assign rsp_valid         = rv_ff;
   assign rsp_result_code   = rc_ff;
   assign rsp_notify        = rn_ff;
   assign rsp_notify_handle = rh_ff;
   assign rsp_notify_status = rs_ff;

   // an entry never written reads as its reset contents
   always_comb begin
      eff_w = rd_w_ff;
      if (!rd_v_ff) begin
         eff_w.key        = '0;
         eff_w.has_handle = 1'b0;
         eff_w.handle     = '0;
         eff_w.status     = '1;
         eff_w.left       = NULL_LINK;
         eff_w.right      = LINK_BITS'(rd_idx_ff) + LINK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_w_ff   <= mem[ra];
      rd_idx_ff <= ra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[wa] <= 1'b1;
         end
         rd_v_ff <= vld_ff[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         root_ff <= NULL_LINK;
         free_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         st_ff   <= st_in;
         root_ff <= root_in;
         free_ff <= free_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         hnd_ff  <= req_handle;
         sta_ff  <= req_exit_status;
      end
      rover_ff   <= rover_in;
      last_ff    <= last_in;
      leaf_ff    <= leaf_in;
      prev_ff    <= prev_in;
      last_w_ff  <= last_w_in;
      rover_w_ff <= rover_w_in;
      leaf_w_ff  <= leaf_w_in;
      prev_w_ff  <= prev_w_in;
      last_ok_ff <= last_ok_in;
      lastbit_ff <= lastbit_in;
      rootins_ff <= rootins_in;
      step_ff    <= step_in;
      nh_ff      <= nh_in;
      ns_ff      <= ns_in;
      rc_ff      <= rc_in;
      rn_ff      <= rn_in;
      rh_ff      <= rh_in;
      rs_ff      <= rs_in;
   end

   node_type fill_w, tmp_w;
   logic [LINK_BITS-1:0] nxt;
   logic kbit, absent;

   always_comb begin
      fill_w.key        = key_ff[30:0];
      fill_w.has_handle = func_ff;
      fill_w.handle     = func_ff ? hnd_ff : '0;
      fill_w.status     = func_ff ? 32'd0 : sta_ff;
      fill_w.left       = NULL_LINK;
      fill_w.right      = NULL_LINK;
   end

   always_comb begin
      st_in      = st_ff;
      root_in    = root_ff;
      free_in    = free_ff;
      rover_in   = rover_ff;
      last_in    = last_ff;
      leaf_in    = leaf_ff;
      prev_in    = prev_ff;
      last_w_in  = last_w_ff;
      rover_w_in = rover_w_ff;
      leaf_w_in  = leaf_w_ff;
      prev_w_in  = prev_w_ff;
      last_ok_in = last_ok_ff;
      lastbit_in = lastbit_ff;
      rootins_in = rootins_ff;
      step_in    = step_ff;
      nh_in      = nh_ff;
      ns_in      = ns_ff;
      rv_in      = 1'b0;
      rc_in      = rc_ff;
      rn_in      = 1'b0;
      rh_in      = '0;
      rs_in      = '0;
      ra         = '0;
      we         = 1'b0;
      wa         = '0;
      wd         = fill_w;
      tmp_w      = eff_w;
      nxt        = NULL_LINK;
      kbit       = 1'b0;
      absent     = 1'b0;

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_key[31]) begin
                  rv_in = 1'b1;
                  rc_in = RES_INVALID_KEY;
               end else if (!link_ok(root_ff)) begin
                  if (!link_ok(free_ff)) begin
                     rv_in = 1'b1;
                     rc_in = RES_FULL;
                  end else begin
                     ra         = free_ff[IDX_BITS-1:0];
                     rootins_in = 1'b1;
                     st_in      = S_FREE;
                  end
               end else begin
                  ra         = root_ff[IDX_BITS-1:0];
                  rover_in   = root_ff;
                  last_ok_in = 1'b0;
                  step_in    = '0;
                  rootins_in = 1'b0;
                  st_in      = S_DESC;
               end
            end
         end
         S_DESC: begin
            if (eff_w.key == key_ff[30:0]) begin
               if (eff_w.has_handle == func_ff) begin
                  rv_in = 1'b1;
                  rc_in = RES_ANOMALY;
                  st_in = S_IDLE;
               end else begin
                  nh_in      = func_ff ? hnd_ff : eff_w.handle;
                  ns_in      = func_ff ? eff_w.status : sta_ff;
                  rover_w_in = eff_w;
                  leaf_in    = rover_ff;
                  leaf_w_in  = eff_w;
                  prev_in    = rover_ff;
                  prev_w_in  = eff_w;
                  step_in    = '0;
                  st_in      = S_LCHK;
               end
            end else if (step_ff > STEP_BITS'(CAPACITY)) begin
               absent = 1'b1;
            end else begin
               // branch on the next key bit, least significant first
               kbit       = (step_ff < STEP_BITS'(32)) ? key_ff[step_ff[4:0]] : 1'b0;
               nxt        = kbit ? eff_w.left : eff_w.right;
               last_in    = rover_ff;
               last_w_in  = eff_w;
               last_ok_in = 1'b1;
               lastbit_in = kbit;
               step_in    = step_ff + STEP_BITS'(1);
               if (link_ok(nxt)) begin
                  ra       = nxt[IDX_BITS-1:0];
                  rover_in = nxt;
               end else begin
                  absent = 1'b1;
               end
            end
            if (absent) begin
               if (!link_ok(free_ff) || !last_ok_in) begin
                  rv_in = 1'b1;
                  rc_in = RES_FULL;
                  st_in = S_IDLE;
               end else begin
                  ra    = free_ff[IDX_BITS-1:0];
                  st_in = S_FREE;
               end
            end
         end
         S_FREE: begin
            // pop the free list head and fill it
            free_in = eff_w.right;
            we      = 1'b1;
            wa      = free_ff[IDX_BITS-1:0];
            wd      = fill_w;
            rover_in = free_ff;
            if (rootins_ff) begin
               root_in = free_ff;
               rv_in   = 1'b1;
               rc_in   = func_ff ? RES_WAITER_STORED : RES_TERM_STORED;
               st_in   = S_IDLE;
            end else begin
               st_in = S_LINK;
            end
         end
         S_LINK: begin
            tmp_w = last_w_ff;
            if (lastbit_ff) begin
               tmp_w.left = rover_ff;
            end else begin
               tmp_w.right = rover_ff;
            end
            we    = 1'b1;
            wa    = last_ff[IDX_BITS-1:0];
            wd    = tmp_w;
            rv_in = 1'b1;
            rc_in = func_ff ? RES_WAITER_STORED : RES_TERM_STORED;
            st_in = S_IDLE;
         end
         S_LCHK: begin
            // descend to a leaf, left links first
            if (step_ff < STEP_BITS'(CAPACITY) && link_ok(leaf_w_ff.left)) begin
               prev_in   = leaf_ff;
               prev_w_in = leaf_w_ff;
               leaf_in   = leaf_w_ff.left;
               ra        = leaf_w_ff.left[IDX_BITS-1:0];
               st_in     = S_LRD;
            end else if (step_ff < STEP_BITS'(CAPACITY) && link_ok(leaf_w_ff.right)) begin
               prev_in   = leaf_ff;
               prev_w_in = leaf_w_ff;
               leaf_in   = leaf_w_ff.right;
               ra        = leaf_w_ff.right[IDX_BITS-1:0];
               st_in     = S_LRD;
            end else begin
               st_in = S_REM1;
            end
         end
         S_LRD: begin
            leaf_w_in = eff_w;
            step_in   = step_ff + STEP_BITS'(1);
            st_in     = S_LCHK;
         end
         S_REM1: begin
            if (leaf_ff == root_ff) begin
               root_in = NULL_LINK;
            end else if (leaf_ff == rover_ff) begin
               if (last_ok_ff) begin
                  tmp_w = last_w_ff;
                  if (last_w_ff.left == rover_ff) begin
                     tmp_w.left = NULL_LINK;
                  end else begin
                     tmp_w.right = NULL_LINK;
                  end
                  we = 1'b1;
                  wa = last_ff[IDX_BITS-1:0];
                  wd = tmp_w;
               end
            end else begin
               // move the leaf's contents up into the matched node
               tmp_w            = rover_w_ff;
               tmp_w.key        = leaf_w_ff.key;
               tmp_w.has_handle = leaf_w_ff.has_handle;
               tmp_w.handle     = leaf_w_ff.handle;
               tmp_w.status     = leaf_w_ff.status;
               if (prev_ff == rover_ff) begin
                  if (rover_w_ff.left == leaf_ff) begin
                     tmp_w.left = NULL_LINK;
                  end else begin
                     tmp_w.right = NULL_LINK;
                  end
               end
               we = 1'b1;
               wa = rover_ff[IDX_BITS-1:0];
               wd = tmp_w;
            end
            st_in = S_REM2;
         end
         S_REM2: begin
            if (leaf_ff != root_ff && leaf_ff != rover_ff && prev_ff != rover_ff) begin
               tmp_w = prev_w_ff;
               if (prev_w_ff.left == leaf_ff) begin
                  tmp_w.left = NULL_LINK;
               end else begin
                  tmp_w.right = NULL_LINK;
               end
               we = 1'b1;
               wa = prev_ff[IDX_BITS-1:0];
               wd = tmp_w;
            end
            st_in = S_REM3;
         end
         S_REM3: begin
            // clear the leaf and push it on the free list
            tmp_w.key        = '0;
            tmp_w.has_handle = 1'b0;
            tmp_w.handle     = '0;
            tmp_w.status     = '1;
            tmp_w.left       = NULL_LINK;
            tmp_w.right      = free_ff;
            we      = 1'b1;
            wa      = leaf_ff[IDX_BITS-1:0];
            wd      = tmp_w;
            free_in = leaf_ff;
            rv_in   = 1'b1;
            rn_in   = 1'b1;
            rh_in   = nh_ff;
            rs_in   = ns_ff;
            rc_in   = func_ff ? RES_ALREADY_TERM : RES_WAITER_NOTIFY;
            st_in   = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== src/krst_checker.sv =====
module krst_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_result_code,
   input logic        rsp_notify,
   input logic [krst_pkg::HANDLE_BITS-1:0] rsp_notify_handle,
   input logic [31:0] rsp_notify_status
);
   import krst_pkg::*;

   a_idle_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while still busy");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid) else $error("accepted word dropped");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_result_code <= 3'(RES_INVALID_KEY)) else $error("bad result code");

   a_notify_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notify |->
         rsp_result_code == 3'(RES_WAITER_NOTIFY) || rsp_result_code == 3'(RES_ALREADY_TERM))
      else $error("notify with wrong code");

   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_notify |-> rsp_notify_handle == '0 && rsp_notify_status == '0)
      else $error("notify fields set without notify");

endmodule

bind key_rendezvous_search_tree krst_checker u_krst_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_result_code(rsp_result_code),
   .rsp_notify(rsp_notify), .rsp_notify_handle(rsp_notify_handle),
   .rsp_notify_status(rsp_notify_status)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import krst_pkg::*;

   localparam int DEPTH = CAPACITY;
   localparam logic [LINK_BITS-1:0] NIL = NULL_LINK;
   localparam int RANDOM_WORDS = 320;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [2:0]             code;
      logic                   notify;
      logic [HANDLE_BITS-1:0] hnd;
      logic [31:0]            st;
   } rendezvous_word_type;

   // Shadow copy of the key table and its free list; predicts each response word.
   class rendezvous_board;
      logic [31:0]            shadow_key [DEPTH];
      logic                   shadow_has_hnd [DEPTH];
      logic [HANDLE_BITS-1:0] shadow_hnd [DEPTH];
      logic [31:0]            shadow_st [DEPTH];
      logic [LINK_BITS-1:0]   shadow_left [DEPTH];
      logic [LINK_BITS-1:0]   shadow_right [DEPTH];
      logic [LINK_BITS-1:0]   root;
      logic [LINK_BITS-1:0]   free_head;
      rendezvous_word_type    pending_words [$];
      int                     mismatches;

      function new();
         for (int i = 0; i < DEPTH; i++) begin
            wipe(i);
            shadow_right[i] = LINK_BITS'(i + 1);
         end
         root = NIL;
         free_head = 0;
         mismatches = 0;
      endfunction

      function void wipe(int i);
         shadow_key[i] = 0;
         shadow_has_hnd[i] = 0;
         shadow_hnd[i] = 0;
         shadow_st[i] = '1;
         shadow_left[i] = NIL;
      endfunction

      function void store(int n, logic [31:0] k, logic f, logic [HANDLE_BITS-1:0] h,
                          logic [31:0] s);
         free_head = shadow_right[n];
         shadow_key[n] = {1'b0, k[30:0]};
         shadow_has_hnd[n] = f;
         shadow_hnd[n] = f ? h : '0;
         shadow_st[n] = f ? 32'd0 : s;
         shadow_left[n] = NIL;
         shadow_right[n] = NIL;
      endfunction

      // Note an accepted request word: walk the shadow tree and queue the answer.
      function void note_request(logic f, logic [31:0] k, logic [HANDLE_BITS-1:0] h,
                                 logic [31:0] s);
         rendezvous_word_type w;
         logic [LINK_BITS-1:0] rover, last, leaf, prev, n;
         logic [31:0] mask, lastbit;
         int steps;
         w = '{RES_INVALID_KEY, 1'b0, '0, '0};
         if (k[31]) begin
            w.code = RES_INVALID_KEY;
         end else if (!link_ok(root)) begin
            if (!link_ok(free_head)) w.code = RES_FULL;
            else begin
               n = free_head;
               store(n, k, f, h, s);
               root = n;
               w.code = f ? RES_WAITER_STORED : RES_TERM_STORED;
            end
         end else begin
            rover = root; last = NIL; mask = 1; lastbit = 1; steps = 0;
            while (link_ok(rover) && k != shadow_key[rover] && steps <= DEPTH) begin
               last = rover;
               lastbit = mask;
               rover = (k & mask) ? shadow_left[last] : shadow_right[last];
               mask = mask << 1;
               steps++;
            end
            if (!link_ok(rover) || k != shadow_key[rover]) begin
               if (!link_ok(free_head) || !link_ok(last)) w.code = RES_FULL;
               else begin
                  n = free_head;
                  store(n, k, f, h, s);
                  if (k & lastbit) shadow_left[last] = n;
                  else shadow_right[last] = n;
                  w.code = f ? RES_WAITER_STORED : RES_TERM_STORED;
               end
            end else if (shadow_has_hnd[rover] == f) begin
               w.code = RES_ANOMALY;
            end else begin
               w.notify = 1;
               if (f) begin
                  w.hnd = h; w.st = shadow_st[rover]; w.code = RES_ALREADY_TERM;
               end else begin
                  w.hnd = shadow_hnd[rover]; w.st = s; w.code = RES_WAITER_NOTIFY;
               end
               // descend to a leaf, left links first
               leaf = rover; prev = rover; steps = 0;
               while (steps < DEPTH) begin
                  if (link_ok(shadow_left[leaf])) begin
                     prev = leaf; leaf = shadow_left[leaf];
                  end else if (link_ok(shadow_right[leaf])) begin
                     prev = leaf; leaf = shadow_right[leaf];
                  end else break;
                  steps++;
               end
               if (leaf == root) root = NIL;
               else if (leaf == rover) begin
                  if (link_ok(last)) begin
                     if (shadow_left[last] == rover) shadow_left[last] = NIL;
                     else shadow_right[last] = NIL;
                  end
               end else begin
                  shadow_key[rover] = shadow_key[leaf];
                  shadow_has_hnd[rover] = shadow_has_hnd[leaf];
                  shadow_hnd[rover] = shadow_hnd[leaf];
                  shadow_st[rover] = shadow_st[leaf];
                  if (shadow_left[prev] == leaf) shadow_left[prev] = NIL;
                  else shadow_right[prev] = NIL;
               end
               wipe(leaf);
               shadow_right[leaf] = free_head;
               free_head = leaf;
            end
         end
         pending_words.push_back(w);
      endfunction

      // Check a response word against the oldest prediction.
      function void check_response(rendezvous_word_type got);
         rendezvous_word_type exp;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word code=%0d", got.code);
            return;
         end
         exp = pending_words.pop_front();
         if (got.code !== exp.code || got.notify !== exp.notify ||
             got.hnd !== exp.hnd || got.st !== exp.st) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp code=%0d n=%0b h=%h s=%h  got code=%0d n=%0b h=%h s=%h",
                        exp.code, exp.notify, exp.hnd, exp.st,
                        got.code, got.notify, got.hnd, got.st);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic req_func = 0;
   logic signed [31:0] req_key = 0;
   logic [HANDLE_BITS-1:0] req_handle = 0;
   logic signed [31:0] req_exit_status = 0;
   logic rsp_valid;
   logic [2:0] rsp_result_code;
   logic rsp_notify;
   logic [HANDLE_BITS-1:0] rsp_notify_handle;
   logic signed [31:0] rsp_notify_status;

   rendezvous_board board = new();
   int cycle_count = 0;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   key_rendezvous_search_tree dut (.*);

   // Sample the response strobe at each edge; it lasts one cycle only.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_response('{rsp_result_code, rsp_notify, rsp_notify_handle,
                                rsp_notify_status});
   end

   // Watchdog: drop the run if the block stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Drive one request word: hold start until the block takes it.
   // A word is taken at an edge with start high and busy low; note it there.
   // Leave start high on return so a word with no gap follows at once.
   task automatic send_word(logic f, logic [31:0] k, logic [HANDLE_BITS-1:0] h,
                            logic [31:0] s);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_func <= f;
      req_key <= k;
      req_handle <= h;
      req_exit_status <= s;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(f, k, h, s);
   endtask

   int key_pool [$];

   // Pick a key: mostly from a small set so matches and removals happen often.
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return {1'b1, 31'($urandom)};
      if (r < 70) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 85) return {1'b0, 31'($urandom)};
      return 32'($urandom_range(0, 63));
   endfunction

   initial begin
      logic [31:0] k;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, each outcome but the full table, a removal deep in the tree.
      send_word(1, 32'h8000_0000, 16'hFFFF, 32'h0);
      send_word(0, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF);
      send_word(1, 32'h7FFF_FFFF, 16'hFFFF, 32'h0);
      send_word(1, 32'h7FFF_FFFF, 16'h1234, 32'h0);
      send_word(0, 32'h7FFF_FFFF, 16'h0, 32'h8000_0000);
      send_word(0, 32'h0, 16'hFFFF, 32'h7FFF_FFFF);
      send_word(0, 32'h0, 16'h0, 32'h1);
      send_word(1, 32'h0, 16'hFFFF, 32'hFFFF_FFFF);
      for (int i = 1; i <= 8; i++) send_word(1, 32'(i), 16'(i * 311), 32'(i));
      send_word(0, 32'd1, 16'h0, 32'hDEAD_BEEF);
      send_word(0, 32'd4, 16'h0, 32'hFFFF_FFFF);
      send_word(0, 32'd8, 16'h0, 32'h0);
      send_word(1, 32'd2, 16'h0, 32'h0);
      for (int i = 0; i < 40; i++) key_pool.push_back($urandom_range(0, 255));
      for (int i = 0; i < 20; i++) key_pool.push_back({1'b0, 31'($urandom)});

      // Random words; one burst fills the node table to reach the full case.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         k = pick_key();
         send_word(1'($urandom_range(0, 1)), k, 16'($urandom), $urandom);
         if (i == 300)
            for (int j = 0; j < 270; j++)
               send_word(1, 32'(1000 + j), 16'($urandom), $urandom);
      end
      start <= 0;

      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (board.mismatches == 0 && board.pending_words.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/krst_pkg.sv
src/key_rendezvous_search_tree.sv
src/krst_checker.sv
dv/tb_top.sv
